// ----- rtl/pwsa_pkg.sv -----
`default_nettype none

package pwsa_pkg;

  // Fixed field widths of the transaction payload.
  localparam int DATA_W      = 64;
  localparam int PHASE_W     = 2;

  // Default qubits per word; the top level may narrow it.
  localparam int WORD_BITS_DEF = 64;

  // Depth of the queue between front and back (power of two).
  localparam int QUEUE_DEPTH = 4;

  // One classified word as it waits in the queue.
  typedef struct packed {
    logic [DATA_W-1:0]  prod_x;
    logic [DATA_W-1:0]  prod_z;
    logic [PHASE_W-1:0] lhs_phase;
    logic [PHASE_W-1:0] rhs_phase;
    logic               last;
    logic               sign_par;   // parity of lhs.z & rhs.x
    logic               comm_par;   // anticommutation parity of this word
    logic [1:0]         y_cnt;      // lhs Y count of this word, mod 4
  } pwsa_entry_t;

  typedef struct packed {
    logic        push;
    pwsa_entry_t entry;
  } pwsa_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pwsa_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/pwsa_front.sv -----
`default_nettype none

module pwsa_front #(
  parameter int WORD_BITS = pwsa_pkg::WORD_BITS_DEF
) (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_lhs_x_word,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_lhs_z_word,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_rhs_x_word,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_rhs_z_word,
  input  wire logic [pwsa_pkg::PHASE_W-1:0] in_lhs_phase,
  input  wire logic [pwsa_pkg::PHASE_W-1:0] in_rhs_phase,
  input  wire logic                         in_last_word,
  input  wire pwsa_pkg::pwsa_qstat_t        qstat_i,
  output pwsa_pkg::pwsa_push_t              push_o
);

  localparam int DW = pwsa_pkg::DATA_W;
  localparam int NBYTES = DW / 8;
  localparam logic [DW-1:0] MASK = {DW{1'b1}} >> (DW - WORD_BITS);

  // popcount mod 4, one byte at a time
  function automatic logic [1:0] ones_mod4(input logic [DW-1:0] v);
    logic [1:0] acc;
    logic [3:0] cnt;
    acc = 2'd0;
    for (int b = 0; b < NBYTES; b++) begin
      cnt = 4'($countones(v[8*b +: 8]));
      acc = acc + cnt[1:0];
    end
    return acc;
  endfunction

  logic [DW-1:0] lx, lz, rx, rz;
  logic          sp;

  assign lx = in_lhs_x_word & MASK;
  assign lz = in_lhs_z_word & MASK;
  assign rx = in_rhs_x_word & MASK;
  assign rz = in_rhs_z_word & MASK;
  assign sp = ^(lz & rx);

  assign in_stall = qstat_i.full;

  always_comb begin
    push_o.push            = in_valid && !qstat_i.full;
    push_o.entry.prod_x    = lx ^ rx;
    push_o.entry.prod_z    = lz ^ rz;
    push_o.entry.lhs_phase = in_lhs_phase;
    push_o.entry.rhs_phase = in_rhs_phase;
    push_o.entry.last      = in_last_word;
    push_o.entry.sign_par  = sp;
    push_o.entry.comm_par  = (^(lx & rz)) ^ sp;
    push_o.entry.y_cnt     = ones_mod4(lx & lz);
  end

endmodule

`default_nettype wire

// ----- rtl/pwsa_queue.sv -----
`default_nettype none

module pwsa_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pwsa_pkg::pwsa_push_t  push_i,
  input  wire logic                  pop_i,
  output pwsa_pkg::pwsa_qstat_t      qstat_o,
  output pwsa_pkg::pwsa_entry_t      head_o
);

  localparam int DEPTH = pwsa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pwsa_pkg::pwsa_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign qstat_o.full  = (count_r == CNT_W'(DEPTH));
  assign qstat_o.empty = (count_r == '0);
  assign head_o        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i.push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (push_i.push && !pop_i) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_i && !push_i.push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pwsa_back.sv -----
`default_nettype none

module pwsa_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pwsa_pkg::pwsa_qstat_t         qstat_i,
  input  wire pwsa_pkg::pwsa_entry_t         head_i,
  output logic                               pop_o,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pwsa_pkg::DATA_W-1:0]        out_prod_x_word,
  output logic [pwsa_pkg::DATA_W-1:0]        out_prod_z_word,
  output logic [pwsa_pkg::PHASE_W-1:0]       out_prod_phase,
  output logic                               out_anticommutes,
  output logic                               out_squares_to_identity,
  output logic                               out_measure_negative,
  output logic                               out_measure_error,
  output logic                               out_result_last
);

  localparam logic [1:0] COEFF_NEG = 2'd2;

  logic       sign_par_r, sign_par_nxt;
  logic       comm_par_r, comm_par_nxt;
  logic [1:0] y_cnt_r, y_cnt_nxt;
  logic       out_valid_r;

  logic       sp_sum, cp_sum;
  logic [1:0] yc_sum, coeff;

  logic [pwsa_pkg::DATA_W-1:0]  px_r, pz_r;
  logic [pwsa_pkg::PHASE_W-1:0] phase_r;
  logic anti_r, sq_r, neg_r, err_r, last_r;

  assign pop_o = !qstat_i.empty && (!out_valid_r || !out_stall);

  assign sp_sum = sign_par_r ^ head_i.sign_par;
  assign cp_sum = comm_par_r ^ head_i.comm_par;
  assign yc_sum = y_cnt_r + head_i.y_cnt;
  assign coeff  = head_i.lhs_phase - yc_sum;

  always_comb begin
    sign_par_nxt = sign_par_r;
    comm_par_nxt = comm_par_r;
    y_cnt_nxt    = y_cnt_r;
    if (pop_o) begin
      // last word closes the pair of strings
      sign_par_nxt = head_i.last ? 1'b0 : sp_sum;
      comm_par_nxt = head_i.last ? 1'b0 : cp_sum;
      y_cnt_nxt    = head_i.last ? 2'd0 : yc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_par_r  <= 1'b0;
      comm_par_r  <= 1'b0;
      y_cnt_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      sign_par_r <= sign_par_nxt;
      comm_par_r <= comm_par_nxt;
      y_cnt_r    <= y_cnt_nxt;
      if (pop_o) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      px_r    <= head_i.prod_x;
      pz_r    <= head_i.prod_z;
      last_r  <= head_i.last;
      phase_r <= head_i.last ?
                 (head_i.lhs_phase + head_i.rhs_phase + {sp_sum, 1'b0}) : 2'd0;
      anti_r  <= head_i.last && cp_sum;
      sq_r    <= head_i.last && !coeff[0];
      neg_r   <= head_i.last && (coeff == COEFF_NEG);
      err_r   <= head_i.last && coeff[0];
    end
  end

  assign out_valid               = out_valid_r;
  assign out_prod_x_word         = px_r;
  assign out_prod_z_word         = pz_r;
  assign out_prod_phase          = phase_r;
  assign out_anticommutes        = anti_r;
  assign out_squares_to_identity = sq_r;
  assign out_measure_negative    = neg_r;
  assign out_measure_error       = err_r;
  assign out_result_last         = last_r;

endmodule

`default_nettype wire

// ----- rtl/pauli_word_serial_alu.sv -----
// Word-serial ALU for two Pauli strings in symplectic form. Each input
// transaction carries one word of x and z bits for both operands (the low
// WORD_BITS bits are used, upper bits are ignored and return as zero), and
// yields exactly one result transaction holding the product's x and z words
// (XOR of the operands). Across the words of a string pair the block keeps
// the sign parity popcount(lhs.z & rhs.x), the anticommutation parity and
// the lhs Y count mod 4; on the transaction flagged last_word it also
// reports the product phase, the commutation verdict, whether lhs squares
// to identity and the lhs measurement sign (measure_error when the lhs
// coefficient is imaginary), then clears the running state for the next
// pair. Phases are read only on the last word; the summary outputs read
// zero on other words. Throughput is one word per clock, sustained with no
// bubbles while out_stall is low. out_valid is registered: the front
// classifies and writes the queue at the accept edge, and the back folds
// the queue head into the running state and loads the output register
// when it pops that word, which a stalled output can delay. in_stall rises
// only once the four-entry queue is full behind a stalled output.
`default_nettype none

module pauli_word_serial_alu #(
  parameter int WORD_BITS = pwsa_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_lhs_x_word,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_lhs_z_word,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_rhs_x_word,
  input  wire logic [pwsa_pkg::DATA_W-1:0]  in_rhs_z_word,
  input  wire logic [pwsa_pkg::PHASE_W-1:0] in_lhs_phase,
  input  wire logic [pwsa_pkg::PHASE_W-1:0] in_rhs_phase,
  input  wire logic                         in_last_word,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pwsa_pkg::DATA_W-1:0]       out_prod_x_word,
  output logic [pwsa_pkg::DATA_W-1:0]       out_prod_z_word,
  output logic [pwsa_pkg::PHASE_W-1:0]      out_prod_phase,
  output logic                              out_anticommutes,
  output logic                              out_squares_to_identity,
  output logic                              out_measure_negative,
  output logic                              out_measure_error,
  output logic                              out_result_last
);

  pwsa_pkg::pwsa_push_t  push;
  pwsa_pkg::pwsa_qstat_t qstat;
  pwsa_pkg::pwsa_entry_t head;
  logic                  pop;

  // Front: masks the words, forms product words, per-word parities and
  // Y count. Stalls only when the queue is full.
  pwsa_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_lhs_x_word (in_lhs_x_word),
    .in_lhs_z_word (in_lhs_z_word),
    .in_rhs_x_word (in_rhs_x_word),
    .in_rhs_z_word (in_rhs_z_word),
    .in_lhs_phase  (in_lhs_phase),
    .in_rhs_phase  (in_rhs_phase),
    .in_last_word  (in_last_word),
    .qstat_i       (qstat),
    .push_o        (push)
  );

  // Short queue decouples the two sides; a stalled output fills it.
  pwsa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head)
  );

  // Back: running state, last-word verdicts, output register.
  pwsa_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .qstat_i                 (qstat),
    .head_i                  (head),
    .pop_o                   (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_prod_x_word         (out_prod_x_word),
    .out_prod_z_word         (out_prod_z_word),
    .out_prod_phase          (out_prod_phase),
    .out_anticommutes        (out_anticommutes),
    .out_squares_to_identity (out_squares_to_identity),
    .out_measure_negative    (out_measure_negative),
    .out_measure_error       (out_measure_error),
    .out_result_last         (out_result_last)
  );

endmodule

`default_nettype wire

// ----- rtl/pwsa_checker.sv -----
`default_nettype none

module pwsa_props (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [pwsa_pkg::DATA_W-1:0]  in_lhs_x_word,
  input wire logic [pwsa_pkg::DATA_W-1:0]  in_lhs_z_word,
  input wire logic [pwsa_pkg::DATA_W-1:0]  in_rhs_x_word,
  input wire logic [pwsa_pkg::DATA_W-1:0]  in_rhs_z_word,
  input wire logic [pwsa_pkg::PHASE_W-1:0] in_lhs_phase,
  input wire logic [pwsa_pkg::PHASE_W-1:0] in_rhs_phase,
  input wire logic                         in_last_word,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [pwsa_pkg::DATA_W-1:0]  out_prod_x_word,
  input wire logic [pwsa_pkg::DATA_W-1:0]  out_prod_z_word,
  input wire logic [pwsa_pkg::PHASE_W-1:0] out_prod_phase,
  input wire logic                         out_anticommutes,
  input wire logic                         out_squares_to_identity,
  input wire logic                         out_measure_negative,
  input wire logic                         out_measure_error,
  input wire logic                         out_result_last
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // summary fields are zero on words that are not last
  a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_last |->
      out_prod_phase == 2'd0 && !out_anticommutes && !out_squares_to_identity
      && !out_measure_negative && !out_measure_error)
    else $error("summary nonzero on a middle word");

  // imaginary coefficient never reports a sign
  a_err_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_last |-> !(out_measure_negative && out_measure_error))
    else $error("sign and error both set");

  // real coefficient iff lhs squares to identity
  a_sq_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_last |-> out_squares_to_identity != out_measure_error)
    else $error("squares_to_identity disagrees with measure_error");

endmodule

bind pauli_word_serial_alu pwsa_props u_pwsa_checker (.*);

`default_nettype wire
